/* rtl/itp_pkg.sv */
// shared types, character codes and priority function for the infix to postfix converter
package itp_pkg;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_UNMATCHED = 2'd1,
		ERR_OVERFLOW  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		K_NOP    = 3'd0,
		K_LETTER = 3'd1,
		K_OPEN   = 3'd2,
		K_CLOSE  = 3'd3,
		K_OPER   = 3'd4,
		K_FLUSH  = 3'd5
	} kind_t;

	typedef logic [1:0] prio_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] symbol;
		prio_t      prio;
	} op_t;

	typedef struct packed {
		logic push;
		op_t  op;
	} q_wr_t;

	typedef struct packed {
		logic avail;
		op_t  op;
	} q_rd_t;

	function automatic prio_t prio_of(input logic [7:0] c);
		prio_t p;
		case (c)
			CH_LPAREN: p = 2'd1;
			CH_PLUS, CH_MINUS: p = 2'd2;
			CH_STAR, CH_SLASH: p = 2'd3;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

/* rtl/itp_item_if.sv */
// request channel carrying one infix character or an end marker
interface itp_item_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] symbol;

	modport source(output valid, output mode, output symbol, input ready);
	modport sink(input valid, input mode, input symbol, output ready);
endinterface

/* rtl/itp_result_if.sv */
// result channel carrying one postfix character or an error marker
interface itp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_symbol;
	logic       is_last;
	logic [1:0] error;

	modport source(output valid, output out_symbol, output is_last, output error, input ready);
	modport sink(input valid, input out_symbol, input is_last, input error, output ready);
endinterface

/* rtl/itp_front.sv */
// front end: takes requests and sorts each character into an operation for the queue
module itp_front (
	itp_item_if.sink       item,
	input  logic           q_full,
	output itp_pkg::q_wr_t q_wr
);

	logic is_letter;

	assign is_letter = ((item.symbol >= 8'h41) && (item.symbol <= 8'h5A)) ||
		((item.symbol >= 8'h61) && (item.symbol <= 8'h7A));

	assign item.ready = !q_full;

	always_comb begin
		q_wr.push      = item.valid && !q_full;
		q_wr.op.symbol = item.symbol;
		q_wr.op.prio   = itp_pkg::prio_of(item.symbol);
		if (item.mode) begin
			q_wr.op.kind = itp_pkg::K_FLUSH;
		end else if (is_letter) begin
			q_wr.op.kind = itp_pkg::K_LETTER;
		end else if (item.symbol == itp_pkg::CH_LPAREN) begin
			q_wr.op.kind = itp_pkg::K_OPEN;
		end else if (item.symbol == itp_pkg::CH_RPAREN) begin
			q_wr.op.kind = itp_pkg::K_CLOSE;
		end else begin
			q_wr.op.kind = itp_pkg::K_OPER;
		end
	end

endmodule

/* rtl/itp_queue.sv */
// two-entry queue of sorted operations between front end and stack engine
module itp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  itp_pkg::q_wr_t wr,
	input  logic           pop,
	output itp_pkg::q_rd_t rd,
	output logic           full
);

	itp_pkg::op_t ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd.avail = (cnt_q != 2'd0);
	assign rd.op    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			ent_q[wr_ptr_q] <= wr.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr.push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/itp_back.sv */
// stack engine: runs each operation against the operator stack and emits results
module itp_back #(
	parameter int DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  itp_pkg::q_rd_t q_rd,
	output logic           q_pop,
	itp_result_if.source   result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_FILL = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t         state_q, state_d;
	logic [7:0]     stack_mem [DEPTH];
	logic [CW-1:0]  cnt_q;
	logic [7:0]     top_q;
	logic [7:0]     rd_q;
	logic [AW-1:0]  rd_addr;
	itp_pkg::op_t   cur_q;

	logic           pend_valid_q;
	logic [7:0]     pend_sym_q;
	itp_pkg::err_t  pend_err_q;

	logic           out_valid_q;
	logic [7:0]     out_sym_q;
	logic           out_last_q;
	itp_pkg::err_t  out_err_q;

	logic           out_free, full, empty, stall;
	logic           gen, do_push, do_pop, set_nop, flush_pend, deq;
	logic [7:0]     gen_sym;
	itp_pkg::err_t  gen_err;
	itp_pkg::prio_t top_prio;

	assign out_free = !out_valid_q || result.ready;
	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign top_prio = itp_pkg::prio_of(top_q);
	// entry just under the top, fetched ahead so a pop can reload the top register
	assign rd_addr  = (cnt_q >= CW'(2)) ? AW'(cnt_q - CW'(2)) : '0;
	assign q_pop    = deq;

	always_comb begin
		state_d    = state_q;
		gen        = 1'b0;
		gen_sym    = '0;
		gen_err    = itp_pkg::ERR_NONE;
		do_push    = 1'b0;
		do_pop     = 1'b0;
		set_nop    = 1'b0;
		flush_pend = 1'b0;
		deq        = 1'b0;
		stall      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_rd.avail) begin
					deq     = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cur_q.kind)
					itp_pkg::K_LETTER: begin
						gen     = 1'b1;
						gen_sym = cur_q.symbol;
						state_d = ST_DONE;
					end
					itp_pkg::K_OPEN: begin
						if (full) begin
							gen     = 1'b1;
							gen_err = itp_pkg::ERR_OVERFLOW;
						end else begin
							do_push = 1'b1;
						end
						state_d = ST_DONE;
					end
					itp_pkg::K_OPER: begin
						if (!empty && (top_prio >= cur_q.prio)) begin
							gen     = 1'b1;
							gen_sym = top_q;
							do_pop  = 1'b1;
							state_d = ST_FILL;
						end else if (full) begin
							gen     = 1'b1;
							gen_err = itp_pkg::ERR_OVERFLOW;
							state_d = ST_DONE;
						end else begin
							do_push = 1'b1;
							state_d = ST_DONE;
						end
					end
					itp_pkg::K_CLOSE: begin
						if (empty) begin
							gen     = 1'b1;
							gen_err = itp_pkg::ERR_UNMATCHED;
							state_d = ST_DONE;
						end else if (top_q == itp_pkg::CH_LPAREN) begin
							// matching paren is dropped, then nothing left to do
							do_pop  = 1'b1;
							set_nop = 1'b1;
							state_d = ST_FILL;
						end else begin
							gen     = 1'b1;
							gen_sym = top_q;
							do_pop  = 1'b1;
							state_d = ST_FILL;
						end
					end
					itp_pkg::K_FLUSH: begin
						if (empty) begin
							state_d = ST_DONE;
						end else begin
							gen     = 1'b1;
							gen_sym = top_q;
							do_pop  = 1'b1;
							state_d = ST_FILL;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
				// a new result pushes the held one out, which needs a free output slot
				if (gen && pend_valid_q && !out_free) begin
					stall   = 1'b1;
					gen     = 1'b0;
					do_push = 1'b0;
					do_pop  = 1'b0;
					set_nop = 1'b0;
					state_d = state_q;
				end
			end
			ST_FILL: begin
				state_d = ST_EXEC;
			end
			ST_DONE: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush_pend = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			stack_mem[cnt_q[AW-1:0]] <= cur_q.symbol;
		end
		rd_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			cur_q <= q_rd.op;
		end else if (set_nop) begin
			cur_q.kind <= itp_pkg::K_NOP;
		end
		if (do_push) begin
			top_q <= cur_q.symbol;
		end else if (state_q == ST_FILL) begin
			top_q <= rd_q;
		end
		if (gen) begin
			pend_sym_q <= gen_sym;
			pend_err_q <= gen_err;
		end
		if ((gen && pend_valid_q) || flush_pend) begin
			out_sym_q  <= pend_sym_q;
			out_err_q  <= pend_err_q;
			out_last_q <= flush_pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_push) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (gen) begin
				pend_valid_q <= 1'b1;
			end else if (flush_pend) begin
				pend_valid_q <= 1'b0;
			end
			if ((gen && pend_valid_q) || flush_pend) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_symbol = out_sym_q;
	assign result.is_last    = out_last_q;
	assign result.error      = out_err_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("stack count beyond depth");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held result left behind at end of request");

	a_fill_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> ($past(cnt_q) == cnt_q + CW'(1)))
		else $error("top reload without a pop");

	a_err_zero_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_err_q != itp_pkg::ERR_NONE)) |-> (out_sym_q == '0))
		else $error("error result with nonzero symbol");

	a_stall_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> ($stable(cnt_q) && (state_q == ST_EXEC)))
		else $error("stack moved during output stall");

endmodule

/* rtl/infix_to_postfix_converter.sv */
// top level of the infix to postfix converter: front end, queue and stack engine
// a letter passes the queue, current-op register, held-result register and output register
// each popped operator is emitted in ST_EXEC, then ST_FILL reloads the top from stack memory
// each request also passes dequeue (ST_IDLE), decision (ST_EXEC) and final hand-off (ST_DONE)
// the two-entry queue keeps taking requests while the stack engine works, until it is full
// reset clears control and count only; stack memory is not cleared, unread entries never matter
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	itp_item_if.sink     item,
	itp_result_if.source result
);

	itp_pkg::q_wr_t q_wr;
	itp_pkg::q_rd_t q_rd;
	logic           q_full;
	logic           q_pop;

	itp_front u_front (
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	itp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.rd     (q_rd),
		.full   (q_full)
	);

	itp_back #(
		.DEPTH (STACK_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.q_pop  (q_pop),
		.result (result)
	);

endmodule
